@@ hdl/adll_pkg.sv @@
// ----------------------------------------------------------------------------
// adll_pkg: shared types and codes for the array doubly linked list
// Holds the item structs, the operation and status codes and the command
// and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BADPOS = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  position;
    logic [63:0] value_word;
  } in_item_t;

  typedef struct packed {
    logic [5:0] new_index;
    logic [5:0] head_index;
    logic [5:0] tail_index;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic rd_free;
    logic chk;
    logic unlink;
    logic push;
    logic link_new;
    logic link_fix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fault;
    logic is_del;
  } sts_t;

endpackage

@@ hdl/array_doubly_linked_list_core.sv @@
// ----------------------------------------------------------------------------
// array_doubly_linked_list_core: doubly linked list in a fixed node store
// An item is accepted only while idle and steps through the check, the link
// or unlink writes and the result load; no new item is taken until that
// result is loaded. The two link writes of an operation that does not fault
// share the single write port of the next-link memory. Reset is synchronous
// and needs no clearing pass; items are taken at once.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_core #(
  parameter int NODE_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  adll_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output adll_pkg::out_item_t  out_data
);

  import adll_pkg::*;

  cmd_t cmd;
  sts_t sts;

  adll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  adll_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ hdl/adll_ram.sv @@
// ----------------------------------------------------------------------------
// adll_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/adll_dp.sv @@
// ----------------------------------------------------------------------------
// adll_dp: list datapath
// Link and usage memories, head, tail and free list registers, the latched
// item and the result register. Sentinel links live in the head and tail
// registers; nodes at or above the fill mark have never been touched.
// ----------------------------------------------------------------------------
module adll_dp #(
  parameter int NODE_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adll_pkg::in_item_t   in_data,
  input  adll_pkg::cmd_t       cmd,
  output adll_pkg::sts_t       sts,
  output adll_pkg::out_item_t  out_data
);

  import adll_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = IDX_W + 1;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic [1:0]       op_r;
  logic [5:0]       pos_r;
  logic [IDX_W-1:0] at_r;
  logic [IDX_W-1:0] after_r;
  logic [IDX_W-1:0] fresh_r;
  logic [1:0]       status_r;
  out_item_t        out_r;

  logic [IDX_W-1:0] at_c;
  logic [IDX_W-1:0] after_c;
  logic             at_live;
  logic             free_empty;
  logic [1:0]       status_c;

  logic             next_we, prev_we, used_we;
  logic [IDX_W-1:0] next_wa, prev_wa, used_wa;
  logic [IDX_W-1:0] next_wd, prev_wd;
  logic             used_wd;
  logic [IDX_W-1:0] next_ra;
  logic [IDX_W-1:0] next_q, prev_q;
  logic             used_q;

  assign at_c = (in_data.opcode == OP_APPEND) ? tail_r : IDX_W'(in_data.position);
  assign next_ra = cmd.rd_free ? free_head_r : at_c;

  adll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_addr (next_ra),
    .rd_data (next_q)
  );

  adll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_we),
    .wr_addr (prev_wa),
    .wr_data (prev_wd),
    .rd_addr (at_c),
    .rd_data (prev_q)
  );

  adll_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_used_ram (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (used_wa),
    .wr_data (used_wd),
    .rd_addr (at_c),
    .rd_data (used_q)
  );

  always_comb begin
    after_c    = (at_r == '0) ? head_r : next_q;
    at_live    = (pos_r != '0) && (32'(pos_r) < 32'(NODE_COUNT)) &&
                 ({1'b0, at_r} < fill_r) && used_q;
    free_empty = (free_head_r == '0);
    case (op_r)
      OP_INSERT: begin
        if (!at_live) begin
          status_c = STAT_BADPOS;
        end else if (free_empty) begin
          status_c = STAT_FULL;
        end else begin
          status_c = STAT_DONE;
        end
      end
      OP_APPEND: status_c = free_empty ? STAT_FULL : STAT_DONE;
      OP_DELETE: status_c = at_live ? STAT_DONE : STAT_BADPOS;
      default:   status_c = STAT_BADPOS;
    endcase
    sts.fault  = (status_c != STAT_DONE);
    sts.is_del = (op_r == OP_DELETE);
  end

  always_comb begin
    next_we = cmd.unlink | cmd.push | cmd.link_new | cmd.link_fix;
    next_wa = fresh_r;
    next_wd = after_r;
    prev_we = cmd.unlink | cmd.link_new | cmd.link_fix;
    prev_wa = fresh_r;
    prev_wd = at_r;
    used_we = cmd.unlink | cmd.link_new;
    used_wa = free_head_r;
    used_wd = cmd.link_new;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    if (cmd.unlink) begin
      next_wa = prev_q;
      next_wd = after_c;
      prev_wa = after_c;
      prev_wd = prev_q;
      used_wa = at_r;
      if (prev_q == '0) begin
        head_nxt = after_c;
      end
      if (after_c == '0) begin
        tail_nxt = prev_q;
      end
    end
    if (cmd.push) begin
      next_wa       = at_r;
      next_wd       = free_head_r;
      free_head_nxt = at_r;
    end
    if (cmd.link_new) begin
      next_wa = at_r;
      next_wd = free_head_r;
      prev_wa = after_r;
      prev_wd = free_head_r;
      if (at_r == '0) begin
        head_nxt = free_head_r;
      end
      if (after_r == '0) begin
        tail_nxt = free_head_r;
      end
      if ({1'b0, free_head_r} == fill_r) begin
        fill_nxt = fill_r + 1'b1;
        if (fill_r == CNT_W'(NODE_COUNT - 1)) begin
          free_head_nxt = '0;
        end else begin
          free_head_nxt = free_head_r + 1'b1;
        end
      end else begin
        free_head_nxt = next_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= IDX_W'(1);
      fill_r      <= CNT_W'(1);
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      at_r  <= at_c;
    end
    if (cmd.chk) begin
      after_r  <= after_c;
      status_r <= status_c;
      fresh_r  <= '0;
    end
    if (cmd.link_new) begin
      fresh_r <= free_head_r;
    end
    if (cmd.out_load) begin
      out_r.new_index  <= 6'(fresh_r);
      out_r.head_index <= 6'(head_r);
      out_r.tail_index <= 6'(tail_r);
      out_r.status     <= status_r;
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_empty_both : assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == '0) == (tail_r == '0))
    else $error("head and tail disagree on an empty list");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(NODE_COUNT))
    else $error("fill mark beyond the node store");
`endif

endmodule

@@ hdl/adll_ctrl.sv @@
// ----------------------------------------------------------------------------
// adll_ctrl: list operation sequencer
// Steps each operation through check, link or unlink writes (skipped when it
// faults) and the result transfer, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module adll_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  adll_pkg::sts_t  sts,
  output adll_pkg::cmd_t  cmd
);

  import adll_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_POP  = 3'd2;
  localparam logic [2:0] ST_LNK  = 3'd3;
  localparam logic [2:0] ST_DEL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.latch    = (state_r == ST_IDLE) && in_valid;
    cmd.rd_free  = (state_r == ST_CHK);
    cmd.chk      = (state_r == ST_CHK);
    cmd.unlink   = (state_r == ST_CHK) && !sts.fault && sts.is_del;
    cmd.push     = (state_r == ST_DEL);
    cmd.link_new = (state_r == ST_POP);
    cmd.link_fix = (state_r == ST_LNK);
    cmd.out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.fault) begin
          state_nxt = ST_FIN;
        end else if (sts.is_del) begin
          state_nxt = ST_DEL;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP:  state_nxt = ST_LNK;
      ST_LNK:  state_nxt = ST_FIN;
      ST_DEL:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (cmd.out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_check : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHK))
    else $error("accepted transfer did not enter the check step");

  a_fin_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=>
      (state_r == ST_FIN && out_valid_r))
    else $error("result overwrote a pending transfer");

  a_pop_then_link : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (state_r == ST_LNK))
    else $error("node pop not followed by link fix");
`endif

endmodule

@@ dv/array_doubly_linked_list_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_core_test: self-checking bench for the list core
// Drives insert, append and delete operations through the valid/ready input
// channel. Each accepted transfer is applied to a behavioral copy of the node
// store, which predicts new node, head, tail and status. Results are checked
// in order. Phases cover directed corner cases, filling and draining the
// store, random traffic under several idle and stall mixes, and two long
// receiver hold-offs.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_core_test;
  import adll_pkg::*;

  localparam int NODES = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [5:0] succ_of [NODES];
  logic [5:0] pred_of [NODES];
  logic       node_live [NODES];
  logic [5:0] free_top;

  out_item_t pending_results[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;

  array_doubly_linked_list_core #(.NODE_COUNT(NODES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("array_doubly_linked_list_core_test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic bit is_live(logic [5:0] idx);
    return idx != 6'd0 && node_live[idx];
  endfunction

  function automatic logic [5:0] link_after_node(logic [5:0] at);
    logic [5:0] fresh;
    logic [5:0] after;
    fresh = free_top;
    after = succ_of[at];
    free_top = succ_of[fresh];
    succ_of[fresh] = after;
    pred_of[fresh] = at;
    node_live[fresh] = 1'b1;
    pred_of[after] = fresh;
    succ_of[at] = fresh;
    return fresh;
  endfunction

  function automatic out_item_t apply_list_op(in_item_t item);
    out_item_t  res;
    logic [5:0] nx;
    logic [5:0] pv;
    res = '0;
    res.status = STAT_DONE;
    case (item.opcode)
      OP_INSERT: begin
        if (!is_live(item.position)) res.status = STAT_BADPOS;
        else if (free_top == 6'd0) res.status = STAT_FULL;
        else res.new_index = link_after_node(item.position);
      end
      OP_APPEND: begin
        if (free_top == 6'd0) res.status = STAT_FULL;
        else res.new_index = link_after_node(pred_of[0]);
      end
      OP_DELETE: begin
        if (!is_live(item.position)) begin
          res.status = STAT_BADPOS;
        end else begin
          nx = succ_of[item.position];
          pv = pred_of[item.position];
          pred_of[nx] = pv;
          succ_of[pv] = nx;
          pred_of[item.position] = 6'd0;
          node_live[item.position] = 1'b0;
          succ_of[item.position] = free_top;
          free_top = item.position;
        end
      end
      default: res.status = STAT_BADPOS;
    endcase
    res.head_index = succ_of[0];
    res.tail_index = pred_of[0];
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("new_index", want.new_index, out_data.new_index);
        check_field("head_index", want.head_index, out_data.head_index);
        check_field("tail_index", want.tail_index, out_data.tail_index);
        check_field("status", want.status, out_data.status);
      end
    end
  end

  function automatic in_item_t list_op(logic [1:0] op, logic [5:0] pos, logic [63:0] val);
    in_item_t item;
    item.opcode = op;
    item.position = pos;
    item.value_word = val;
    return item;
  endfunction

  function automatic logic [5:0] pick_live();
    logic [5:0] cands[$];
    for (int i = 1; i < NODES; i++)
      if (node_live[i]) cands.push_back(6'(i));
    if (cands.size() == 0) return 6'($urandom_range(NODES - 1));
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  function automatic in_item_t random_op(int grow_pct);
    in_item_t item;
    int       roll;
    item.value_word = {$urandom, $urandom};
    item.position = 6'($urandom_range(NODES - 1));
    roll = $urandom_range(99);
    if (roll < 10) begin
      item.opcode = 2'($urandom_range(3));
    end else if (roll < 10 + grow_pct) begin
      item.opcode = $urandom_range(1) ? OP_APPEND : OP_INSERT;
      if (item.opcode == OP_INSERT) item.position = pick_live();
    end else begin
      item.opcode = OP_DELETE;
      item.position = pick_live();
    end
    return item;
  endfunction

  // Entered and left at a falling edge; valid stays high for the next caller.
  task automatic send_op(input in_item_t item);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
      gap++;
    end
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_list_op(item));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_op(list_op(OP_DELETE, 6'd0, '0));
    send_op(list_op(OP_DELETE, 6'd5, '0));
    send_op(list_op(OP_INSERT, 6'd0, '1));
    send_op(list_op(OP_INSERT, 6'd63, '1));
    send_op(list_op(OP_UNUSED, 6'd63, '1));
    send_op(list_op(OP_APPEND, 6'd63, '1));
    send_op(list_op(OP_INSERT, 6'd1, '0));
    send_op(list_op(OP_APPEND, 6'd0, 64'h5555_5555_5555_5555));
    send_op(list_op(OP_INSERT, 6'd3, 64'haaaa_aaaa_aaaa_aaaa));
    send_op(list_op(OP_DELETE, 6'd2, '0));
    send_op(list_op(OP_DELETE, 6'd2, '0));
    send_op(list_op(OP_DELETE, 6'd1, '0));
    send_op(list_op(OP_DELETE, 6'd4, '0));
    send_op(list_op(OP_DELETE, 6'd3, '0));
    send_op(list_op(OP_APPEND, 6'd21, 64'h0123_4567_89ab_cdef));
    send_op(list_op(OP_INSERT, 6'd3, 64'hfedc_ba98_7654_3210));
    send_op(list_op(OP_UNUSED, 6'd0, '0));
    send_op(list_op(OP_DELETE, 6'd3, '0));
    send_op(list_op(OP_DELETE, 6'd4, '0));
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (free_top != 6'd0) begin
      if ($urandom_range(1))
        send_op(list_op(OP_APPEND, 6'($urandom_range(NODES - 1)), {$urandom, $urandom}));
      else
        send_op(list_op(OP_INSERT, pick_live(), {$urandom, $urandom}));
    end
    send_op(list_op(OP_APPEND, 6'd0, '1));
    send_op(list_op(OP_INSERT, pick_live(), '1));
    send_op(list_op(OP_INSERT, 6'd63, '0));
    send_op(list_op(OP_INSERT, 6'd0, '0));
    send_op(list_op(OP_DELETE, 6'd0, '0));
    send_op(list_op(OP_UNUSED, 6'd17, '0));
    send_op(list_op(OP_DELETE, 6'd63, '0));
    send_op(list_op(OP_INSERT, 6'd63, '0));
    while (succ_of[0] != 6'd0) begin
      if ($urandom_range(9) == 0)
        send_op(list_op(OP_DELETE, 6'($urandom_range(NODES - 1)), '0));
      else
        send_op(list_op(OP_DELETE, pick_live(), '0));
    end
    send_op(list_op(OP_APPEND, 6'd42, {$urandom, $urandom}));
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct, int grow_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_op(random_op(grow_pct));
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    repeat (30) send_op(random_op(50));
    wait_drained();
    hold_left = 150;
    repeat (30) send_op(random_op(40));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      succ_of[i] = (i == 0 || i == NODES - 1) ? 6'd0 : 6'(i + 1);
      pred_of[i] = 6'd0;
      node_live[i] = (i == 0);
    end
    free_top = 6'd1;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random_traffic(180, 0, 0, 60);
    test_random_traffic(150, 80, 0, 40);
    test_random_traffic(150, 0, 80, 55);
    test_random_traffic(200, 25, 25, 45);
    test_backpressure();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("array_doubly_linked_list_core_test passed");
    end else begin
      $display("array_doubly_linked_list_core_test failed");
    end
    $finish;
  end

endmodule
